/* rtl/clipped_line_and_rect_rasterizer_unit_assert.svh */
// Assertion macros for the clipped line and rectangle rasterizer.
// Expects clk and rst_n in the scope of the including module.
`ifndef CLIPPED_LINE_AND_RECT_RASTERIZER_UNIT_ASSERT_SVH
`define CLIPPED_LINE_AND_RECT_RASTERIZER_UNIT_ASSERT_SVH

// Condition that holds at every clock edge out of reset.
`define CLR_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define CLR_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

/* rtl/clr_pkg.sv */
// Shared types and constants of the clipped line and rectangle rasterizer.
// Used by every RTL module of the block; depends on nothing.
package clr_pkg;

    localparam logic signed [12:0] SCREEN_W = 13'sd320;
    localparam logic signed [12:0] SCREEN_H = 13'sd240;

    typedef logic signed [11:0] coord_t;

    typedef enum logic [1:0] {
        CMD_LOAD_LINE = 2'd0,
        CMD_LOAD_RECT = 2'd1,
        CMD_STEP      = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_LINE = 2'd1,
        MODE_RECT = 2'd2
    } mode_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  cmd;
        coord_t      first_x;
        coord_t      first_y;
        coord_t      second_x;
        coord_t      second_y;
    } cmd_slot_t;

    typedef struct packed {
        logic        valid;
        coord_t      pixel_x;
        coord_t      pixel_y;
        logic        on_screen;
        logic [15:0] pixel_color;
        logic        last;
    } pixel_slot_t;

endpackage

/* rtl/clr_in_stage.sv */
// Input register of the rasterizer: holds one command transaction.
// Depends on clr_pkg.
module clr_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  clr_pkg::coord_t    first_x,
    input  clr_pkg::coord_t    first_y,
    input  clr_pkg::coord_t    second_x,
    input  clr_pkg::coord_t    second_y,
    input  logic               take,
    output clr_pkg::cmd_slot_t slot
);

    logic            valid_reg;
    logic            valid_next;
    logic [1:0]      cmd_reg;
    clr_pkg::coord_t first_x_reg;
    clr_pkg::coord_t first_y_reg;
    clr_pkg::coord_t second_x_reg;
    clr_pkg::coord_t second_y_reg;
    logic            accept;

    assign in_stall = valid_reg && !take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= cmd;
            first_x_reg  <= first_x;
            first_y_reg  <= first_y;
            second_x_reg <= second_x;
            second_y_reg <= second_y;
        end
    end

    assign slot.valid    = valid_reg;
    assign slot.cmd      = cmd_reg;
    assign slot.first_x  = first_x_reg;
    assign slot.first_y  = first_y_reg;
    assign slot.second_x = second_x_reg;
    assign slot.second_y = second_y_reg;

endmodule

/* rtl/clr_engine.sv */
// Drawing engine: shape state, line and rectangle setup, one step per step command.
// Depends on clr_pkg.
module clr_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [15:0]          cfg_write_data,
    input  clr_pkg::cmd_slot_t   slot,
    input  logic                 out_free,
    output logic                 take,
    output clr_pkg::pixel_slot_t pix
);

    clr_pkg::mode_t  mode_reg, mode_next;
    clr_pkg::coord_t cur_x_reg, cur_x_next;
    clr_pkg::coord_t cur_y_reg, cur_y_next;
    clr_pkg::coord_t tgt_x_reg, tgt_x_next;
    clr_pkg::coord_t tgt_y_reg, tgt_y_next;
    clr_pkg::coord_t row_x_reg, row_x_next;
    logic [11:0]     dx_reg, dx_next;
    logic [11:0]     dy_reg, dy_next;
    logic            sxn_reg, sxn_next;
    logic            syn_reg, syn_next;
    logic signed [12:0] err_reg, err_next;
    logic [15:0]     color_reg;

    // line setup
    logic signed [12:0] x0w, y0w, x1w, y1w;
    logic signed [12:0] sub_x, neg_x, sub_y, neg_y;
    logic [11:0]        dx_load, dy_load;
    logic signed [12:0] err_init;

    // rectangle setup
    logic signed [12:0] rx, ry, rw, rh, sum_w, sum_h, w_clip, h_clip, far_x, far_y;
    logic               rect_ok;

    // step
    logic signed [13:0] e14, dx14, dy14, ndx14, err_sum;
    logic               cond_x, cond_y;
    logic               fin;
    logic               produces;
    logic               on_scr;

    assign x0w = $signed({slot.first_x[11], slot.first_x});
    assign y0w = $signed({slot.first_y[11], slot.first_y});
    assign x1w = $signed({slot.second_x[11], slot.second_x});
    assign y1w = $signed({slot.second_y[11], slot.second_y});

    assign sub_x   = x1w - x0w;
    assign neg_x   = x0w - x1w;
    assign sub_y   = y1w - y0w;
    assign neg_y   = y0w - y1w;
    assign dx_load = (x1w > x0w) ? sub_x[11:0] : neg_x[11:0];
    assign dy_load = (y1w > y0w) ? sub_y[11:0] : neg_y[11:0];
    assign err_init = (dx_load > dy_load) ? $signed({2'b00, dx_load[11:1]})
                                          : $signed(13'd0 - {2'b00, dy_load[11:1]});

    assign rx      = slot.first_x[11] ? 13'sd0 : x0w;
    assign ry      = slot.first_y[11] ? 13'sd0 : y0w;
    assign rw      = x1w;
    assign rh      = y1w;
    assign sum_w   = rx + rw;
    assign sum_h   = ry + rh;
    assign w_clip  = (sum_w >= clr_pkg::SCREEN_W) ? clr_pkg::SCREEN_W - rx : rw;
    assign h_clip  = (sum_h >= clr_pkg::SCREEN_H) ? clr_pkg::SCREEN_H - ry : rh;
    assign rect_ok = (w_clip > 13'sd0) && (h_clip > 13'sd0);
    assign far_x   = rx + w_clip - 13'sd1;
    assign far_y   = ry + h_clip - 13'sd1;

    assign e14     = $signed({err_reg[12], err_reg});
    assign dx14    = $signed({2'b00, dx_reg});
    assign dy14    = $signed({2'b00, dy_reg});
    assign ndx14   = 14'sd0 - dx14;
    assign cond_x  = e14 > ndx14;
    assign cond_y  = e14 < dy14;
    assign err_sum = e14 - (cond_x ? dy14 : 14'sd0) + (cond_y ? dx14 : 14'sd0);

    assign fin      = (cur_x_reg == tgt_x_reg) && (cur_y_reg == tgt_y_reg);
    assign produces = (slot.cmd == clr_pkg::CMD_STEP) && (mode_reg != clr_pkg::MODE_IDLE);
    assign take     = slot.valid && (!produces || out_free);
    assign on_scr   = !cur_x_reg[11] && !cur_y_reg[11]
                   && ($signed({1'b0, cur_x_reg}) < clr_pkg::SCREEN_W)
                   && ($signed({1'b0, cur_y_reg}) < clr_pkg::SCREEN_H);

    always_comb
    begin
        mode_next  = mode_reg;
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        tgt_x_next = tgt_x_reg;
        tgt_y_next = tgt_y_reg;
        row_x_next = row_x_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        sxn_next   = sxn_reg;
        syn_next   = syn_reg;
        err_next   = err_reg;
        if (take)
        begin
            case (slot.cmd)
                clr_pkg::CMD_LOAD_LINE:
                begin
                    cur_x_next = slot.first_x;
                    cur_y_next = slot.first_y;
                    tgt_x_next = slot.second_x;
                    tgt_y_next = slot.second_y;
                    dx_next    = dx_load;
                    dy_next    = dy_load;
                    sxn_next   = !(x0w < x1w);
                    syn_next   = !(y0w < y1w);
                    err_next   = err_init;
                    mode_next  = clr_pkg::MODE_LINE;
                end
                clr_pkg::CMD_LOAD_RECT:
                begin
                    if (rect_ok)
                    begin
                        cur_x_next = rx[11:0];
                        cur_y_next = ry[11:0];
                        row_x_next = rx[11:0];
                        tgt_x_next = far_x[11:0];
                        tgt_y_next = far_y[11:0];
                        mode_next  = clr_pkg::MODE_RECT;
                    end
                    else
                    begin
                        mode_next = clr_pkg::MODE_IDLE;
                    end
                end
                clr_pkg::CMD_STEP:
                begin
                    case (mode_reg)
                        clr_pkg::MODE_LINE:
                        begin
                            if (fin)
                            begin
                                mode_next = clr_pkg::MODE_IDLE;
                            end
                            else
                            begin
                                err_next = err_sum[12:0];
                                if (cond_x)
                                begin
                                    cur_x_next = sxn_reg ? cur_x_reg - 12'sd1
                                                         : cur_x_reg + 12'sd1;
                                end
                                if (cond_y)
                                begin
                                    cur_y_next = syn_reg ? cur_y_reg - 12'sd1
                                                         : cur_y_reg + 12'sd1;
                                end
                            end
                        end
                        clr_pkg::MODE_RECT:
                        begin
                            if (fin)
                            begin
                                mode_next = clr_pkg::MODE_IDLE;
                            end
                            else if (cur_x_reg == tgt_x_reg)
                            begin
                                cur_x_next = row_x_reg;
                                cur_y_next = cur_y_reg + 12'sd1;
                            end
                            else
                            begin
                                cur_x_next = cur_x_reg + 12'sd1;
                            end
                        end
                        default:
                        begin
                            mode_next = mode_reg;
                        end
                    endcase
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= clr_pkg::MODE_IDLE;
            color_reg <= 16'd0;
        end
        else
        begin
            mode_reg <= mode_next;
            if (cfg_write_en)
            begin
                color_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg <= cur_x_next;
        cur_y_reg <= cur_y_next;
        tgt_x_reg <= tgt_x_next;
        tgt_y_reg <= tgt_y_next;
        row_x_reg <= row_x_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        sxn_reg   <= sxn_next;
        syn_reg   <= syn_next;
        err_reg   <= err_next;
    end

    assign pix.valid       = take && produces;
    assign pix.pixel_x     = cur_x_reg;
    assign pix.pixel_y     = cur_y_reg;
    assign pix.on_screen   = on_scr;
    assign pix.pixel_color = color_reg;
    assign pix.last        = fin;

endmodule

/* rtl/clr_out_stage.sv */
// Output register of the rasterizer: holds one pixel transaction for the sink.
// Depends on clr_pkg.
module clr_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  clr_pkg::pixel_slot_t pix,
    output logic                 out_free,
    output logic                 out_valid,
    input  logic                 out_stall,
    output clr_pkg::coord_t      pixel_x,
    output clr_pkg::coord_t      pixel_y,
    output logic                 on_screen,
    output logic [15:0]          pixel_color,
    output logic                 last
);

    logic            valid_reg;
    logic            valid_next;
    clr_pkg::coord_t pixel_x_reg;
    clr_pkg::coord_t pixel_y_reg;
    logic            on_screen_reg;
    logic [15:0]     pixel_color_reg;
    logic            last_reg;

    assign out_free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (pix.valid)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix.valid)
        begin
            pixel_x_reg     <= pix.pixel_x;
            pixel_y_reg     <= pix.pixel_y;
            on_screen_reg   <= pix.on_screen;
            pixel_color_reg <= pix.pixel_color;
            last_reg        <= pix.last;
        end
    end

    assign out_valid   = valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign on_screen   = on_screen_reg;
    assign pixel_color = pixel_color_reg;
    assign last        = last_reg;

endmodule

/* rtl/clipped_line_and_rect_rasterizer_unit.sv */
// Top level of the clipped line and rectangle rasterizer.
// Depends on clr_pkg, clr_in_stage, clr_engine, clr_out_stage and the assert header.
//
//   channel   direction  handshake              payload
//   in        sink       in_valid / in_stall     cmd, first_x, first_y, second_x, second_y
//   out       source     out_valid / out_stall   pixel_x, pixel_y, on_screen, pixel_color, last
//   cfg       sink       cfg_write_en            cfg_write_data (draw color)
//
// One command per cycle while in_stall is low; a step's pixel is held in the output register, which drives out_valid.
// The engine's shape state is updated in the same cycle the command leaves the input register.
// A stalled output register holds the engine's steps back; loads keep flowing.
// Reset is asynchronous: empty registers, idle engine, draw color zero.
`include "clipped_line_and_rect_rasterizer_unit_assert.svh"

module clipped_line_and_rect_rasterizer_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [15:0]        cfg_write_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic signed [11:0] first_x,
    input  logic signed [11:0] first_y,
    input  logic signed [11:0] second_x,
    input  logic signed [11:0] second_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [11:0] pixel_x,
    output logic signed [11:0] pixel_y,
    output logic               on_screen,
    output logic [15:0]        pixel_color,
    output logic               last
);

    clr_pkg::cmd_slot_t   cmd_slot;
    clr_pkg::pixel_slot_t pix_slot;
    logic                 take;
    logic                 out_free;
    logic                 step_taken;

    clr_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .first_x  (first_x),
        .first_y  (first_y),
        .second_x (second_x),
        .second_y (second_y),
        .take     (take),
        .slot     (cmd_slot)
    );

    clr_engine u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .slot           (cmd_slot),
        .out_free       (out_free),
        .take           (take),
        .pix            (pix_slot)
    );

    clr_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix         (pix_slot),
        .out_free    (out_free),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .on_screen   (on_screen),
        .pixel_color (pixel_color),
        .last        (last)
    );

    assign step_taken = take && (cmd_slot.cmd == clr_pkg::CMD_STEP);

    `CLR_ASSERT_ALWAYS(a_push_only_when_free, !pix_slot.valid || out_free, "output overrun")
    `CLR_ASSERT_ALWAYS(a_push_from_step, !pix_slot.valid || step_taken, "pixel from a non-step")
    `CLR_ASSERT_NEXT(a_accept_fills_input, in_valid && !in_stall, cmd_slot.valid, "lost input")

endmodule

/* bench/tb_clipped_line_and_rect_rasterizer_unit.sv */
// Self-checking bench for the clipped line and rectangle rasterizer: random and directed
// commands with random input gaps, random output stalls, a scoreboard-class pixel predictor.
// Depends on clr_pkg and the clipped_line_and_rect_rasterizer_unit RTL.
module tb_clipped_line_and_rect_rasterizer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import clr_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int TARGET_ITEMS = 700;
    localparam int PHASES = 6;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        coord_t      x;
        coord_t      y;
        logic        on;
        logic [15:0] color;
        logic        last;
    } pixel_t;

    class raster_predictor;
        mode_t       mode;
        int          cur_x;
        int          cur_y;
        int          end_x;
        int          end_y;
        int          dx;
        int          dy;
        int          err;
        int          row_x;
        bit          neg_x;
        bit          neg_y;
        logic [15:0] color;
        pixel_t      expected_pixels[$];
        int          mismatches;
        int          pixels_checked;
        int          lines_loaded;
        int          rects_loaded;

        function new();
            mode = MODE_IDLE;
            color = 16'h0000;
        endfunction

        function bit drawing();
            return mode != MODE_IDLE;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void note_command(logic [1:0] op, coord_t fx, coord_t fy, coord_t sx,
                                   coord_t sy);
            int     x0;
            int     y0;
            int     w;
            int     h;
            int     e;
            bit     fin;
            pixel_t p;
            x0 = fx;
            y0 = fy;
            w = sx;
            h = sy;
            case (op)
                CMD_LOAD_LINE:
                begin
                    lines_loaded++;
                    cur_x = x0;
                    cur_y = y0;
                    end_x = w;
                    end_y = h;
                    dx = (w > x0) ? w - x0 : x0 - w;
                    dy = (h > y0) ? h - y0 : y0 - h;
                    neg_x = !(x0 < w);
                    neg_y = !(y0 < h);
                    err = ((dx > dy) ? dx : -dy) / 2;
                    mode = MODE_LINE;
                end
                CMD_LOAD_RECT:
                begin
                    rects_loaded++;
                    if (x0 < 0)
                        x0 = 0;
                    if (y0 < 0)
                        y0 = 0;
                    if (x0 + w >= SCREEN_W)
                        w = SCREEN_W - x0;
                    if (y0 + h >= SCREEN_H)
                        h = SCREEN_H - y0;
                    if (w <= 0 || h <= 0)
                    begin
                        mode = MODE_IDLE;
                    end
                    else
                    begin
                        cur_x = x0;
                        cur_y = y0;
                        row_x = x0;
                        end_x = x0 + w - 1;
                        end_y = y0 + h - 1;
                        mode = MODE_RECT;
                    end
                end
                CMD_STEP:
                begin
                    if (mode != MODE_IDLE)
                    begin
                        p.x = coord_t'(cur_x);
                        p.y = coord_t'(cur_y);
                        p.on = (cur_x >= 0 && cur_y >= 0 && cur_x < SCREEN_W && cur_y < SCREEN_H);
                        p.color = color;
                        fin = (cur_x == end_x && cur_y == end_y);
                        p.last = fin;
                        expected_pixels.push_back(p);
                        if (fin)
                        begin
                            mode = MODE_IDLE;
                        end
                        else if (mode == MODE_LINE)
                        begin
                            e = err;
                            if (e > -dx)
                            begin
                                err -= dy;
                                cur_x += neg_x ? -1 : 1;
                            end
                            if (e < dy)
                            begin
                                err += dx;
                                cur_y += neg_y ? -1 : 1;
                            end
                        end
                        else if (cur_x == end_x)
                        begin
                            cur_x = row_x;
                            cur_y += 1;
                        end
                        else
                        begin
                            cur_x += 1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_pixel(coord_t x, coord_t y, logic on, logic [15:0] col,
                                  logic last);
            pixel_t p;
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected pixel at (%0d, %0d)", x, y);
                mismatches++;
                return;
            end
            p = expected_pixels.pop_front();
            pixels_checked++;
            if (x !== p.x)
            begin
                $error("pixel_x: expected %0d, got %0d", p.x, x);
                mismatches++;
            end
            if (y !== p.y)
            begin
                $error("pixel_y: expected %0d, got %0d", p.y, y);
                mismatches++;
            end
            if (on !== p.on)
            begin
                $error("on_screen: expected %0b, got %0b", p.on, on);
                mismatches++;
            end
            if (col !== p.color)
            begin
                $error("pixel_color: expected %04h, got %04h", p.color, col);
                mismatches++;
            end
            if (last !== p.last)
            begin
                $error("last: expected %0b, got %0b", p.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic [15:0] cfg_write_data = 16'h0000;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd = CMD_STEP;
    coord_t      first_x = '0;
    coord_t      first_y = '0;
    coord_t      second_x = '0;
    coord_t      second_y = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    coord_t      pixel_x;
    coord_t      pixel_y;
    logic        on_screen;
    logic [15:0] pixel_color;
    logic        last;

    raster_predictor tracker = new();
    bit              no_idle = 1'b0;
    int              stall_left = 0;
    int              items_sent = 0;
    int              colors_written = 0;

    clipped_line_and_rect_rasterizer_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .first_x        (first_x),
        .first_y        (first_y),
        .second_x       (second_x),
        .second_y       (second_y),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pixel_x        (pixel_x),
        .pixel_y        (pixel_y),
        .on_screen      (on_screen),
        .pixel_color    (pixel_color),
        .last           (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_stall <= (stall_left > 0);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            tracker.check_pixel(pixel_x, pixel_y, on_screen, pixel_color, last);
            stall_left <= no_idle ? 0 : $urandom_range(0, 8);
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
    end

    function automatic coord_t any_coord();
        return coord_t'($urandom);
    endfunction

    task automatic issue_command(input logic [1:0] op, input coord_t a, input coord_t b,
                                 input coord_t c, input coord_t d);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        first_x <= a;
        first_y <= b;
        second_x <= c;
        second_y <= d;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_command(op, a, b, c, d);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic step_pixel();
        issue_command(CMD_STEP, any_coord(), any_coord(), any_coord(), any_coord());
    endtask

    task automatic drain_pixels();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_color(input logic [15:0] value);
        cfg_write_en <= 1'b1;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        tracker.color = value;
        colors_written++;
    endtask

    task automatic run_directed();
        issue_command(CMD_STEP, 12'sd0, 12'sd0, 12'sd0, 12'sd0);
        issue_command(CMD_UNUSED, 12'sd7, -12'sd7, 12'sd7, -12'sd7);
        issue_command(CMD_LOAD_LINE, 12'sd5, 12'sd5, 12'sd5, 12'sd5);
        step_pixel();
        step_pixel();
        issue_command(CMD_LOAD_LINE, -12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047);
        step_pixel();
        step_pixel();
        issue_command(CMD_LOAD_LINE, 12'sd2047, -12'sd2048, -12'sd2048, 12'sd2047);
        step_pixel();
        issue_command(CMD_LOAD_LINE, 12'sd0, 12'sd0, 12'sd1, -12'sd3);
        repeat (4) step_pixel();
        issue_command(CMD_LOAD_RECT, -12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047);
        step_pixel();
        issue_command(CMD_LOAD_RECT, 12'sd318, 12'sd238, 12'sd5, 12'sd5);
        repeat (4) step_pixel();
        issue_command(CMD_LOAD_RECT, 12'sd10, 12'sd10, 12'sd0, 12'sd3);
        step_pixel();
        issue_command(CMD_LOAD_RECT, 12'sd2047, 12'sd2047, -12'sd2048, -12'sd2048);
    endtask

    task automatic run_shape();
        int     kind;
        int     cap;
        int     steps;
        coord_t x0;
        coord_t y0;
        kind = $urandom_range(0, 99);
        no_idle = ($urandom_range(0, 5) == 0);
        cap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 100000;
        if (kind < 45)
        begin
            x0 = coord_t'($urandom_range(0, 359) - 20);
            y0 = coord_t'($urandom_range(0, 279) - 20);
            issue_command(CMD_LOAD_LINE, x0, y0, coord_t'(x0 + $urandom_range(0, 32) - 16),
                          coord_t'(y0 + $urandom_range(0, 32) - 16));
        end
        else if (kind < 80)
        begin
            issue_command(CMD_LOAD_RECT, coord_t'($urandom_range(0, 335) - 8),
                          coord_t'($urandom_range(0, 255) - 8),
                          coord_t'($urandom_range(0, 11) - 3),
                          coord_t'($urandom_range(0, 11) - 3));
        end
        else if (kind < 95)
        begin
            cap = $urandom_range(1, 6);
            issue_command((kind < 88) ? CMD_LOAD_LINE : CMD_LOAD_RECT, any_coord(),
                          any_coord(), any_coord(), any_coord());
        end
        else
        begin
            cap = $urandom_range(1, 6);
            issue_command(2'($urandom_range(0, 3)), any_coord(), any_coord(), any_coord(),
                          any_coord());
        end
        steps = 0;
        while (tracker.drawing() && steps < cap)
        begin
            if ($urandom_range(0, 29) == 0)
                issue_command(CMD_UNUSED, any_coord(), any_coord(), any_coord(), any_coord());
            step_pixel();
            steps++;
        end
        if ($urandom_range(0, 9) == 0)
            step_pixel();
    endtask

    initial
    begin
        logic [15:0] palette[PHASES];
        int          budget;
        palette = '{16'hFFFF, 16'h0000, 16'h5AA5, 16'h8000, 16'h0001, 16'h7FFE};
        palette[2] = 16'($urandom);
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_pixels();
            write_color(palette[ph]);
            if (ph == 0)
                run_directed();
            budget = TARGET_ITEMS * (ph + 1) / PHASES;
            while (items_sent < budget)
                run_shape();
        end
        in_valid <= 1'b0;
        for (int n = 0; n < 5000 && tracker.pending() != 0; n++)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (tracker.pending() != 0)
        begin
            $error("%0d expected pixels never arrived", tracker.pending());
            tracker.mismatches++;
        end
        $display("Sent %0d command transactions (%0d line loads, %0d rect loads)",
                 items_sent, tracker.lines_loaded, tracker.rects_loaded);
        $display("Checked %0d pixels under %0d colors with random gaps and output stalls",
                 tracker.pixels_checked, colors_written);
        if (tracker.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
